@@ rtl/kgi_pkg.sv @@
package kgi_pkg;

    localparam int ANGLE_BITS = 10;
    localparam int VAL_W = 16;
    localparam int DUR_W = 15;
    localparam int PROD_W = VAL_W + 1 + DUR_W;
    localparam int DIV_STAGES = PROD_W;

    localparam logic [1:0] GROUP_ROT = 2'd0;
    localparam logic [1:0] GROUP_MOVE = 2'd1;
    localparam logic [1:0] GROUP_SCALE = 2'd2;
    localparam logic [1:0] GROUP_OTHER = 2'd3;

    typedef struct packed {
        logic [1:0] group_type;
        logic signed [15:0] prev_a;
        logic signed [15:0] prev_b;
        logic signed [15:0] prev_c;
        logic signed [15:0] target_a;
        logic signed [15:0] target_b;
        logic signed [15:0] target_c;
        logic [31:0] elapsed_ticks;
        logic [14:0] frame_duration;
    } in_item_t;

    typedef struct packed {
        logic [1:0] out_type;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic signed [15:0] value_c;
        logic values_written;
        logic reached_frame;
    } out_item_t;

    typedef struct packed {
        logic [1:0] group_type;
        logic reached;
        logic [VAL_W-1:0] target_a;
        logic [VAL_W-1:0] target_b;
        logic [VAL_W-1:0] target_c;
    } side_t;

endpackage

@@ rtl/kgi_lane.sv @@
module kgi_lane
    import kgi_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic                    is_angle,
    input  logic [VAL_W-1:0]        prev,
    input  logic [VAL_W-1:0]        target,
    input  logic [DUR_W-1:0]        step,
    input  logic [DUR_W-1:0]        dur,
    output logic [VAL_W-1:0]        value
);

    localparam int FULL = 1 << ANGLE_BITS;
    localparam int HALF = 1 << (ANGLE_BITS - 1);

    logic signed [VAL_W+1:0] d_wide;
    logic [PROD_W-1:0] mag;
    logic neg;

    logic [PROD_W-1:0] rem_reg [DIV_STAGES];
    logic [PROD_W-1:0] quo_reg [DIV_STAGES+1];
    logic [DUR_W-1:0] dur_reg [DIV_STAGES];
    logic neg_reg [DIV_STAGES+1];
    logic [VAL_W-1:0] base_reg [DIV_STAGES+1];
    logic angle_reg [DIV_STAGES+1];
    logic [PROD_W:0] sh_w [DIV_STAGES];
    logic [PROD_W:0] trial_w [DIV_STAGES];
    logic signed [VAL_W+1:0] d_reg;
    logic [DUR_W-1:0] step_reg;
    logic [DUR_W-1:0] dur0_reg;
    logic [VAL_W-1:0] base0_reg;
    logic angle0_reg;
    logic signed [PROD_W+1:0] prod;

    always_comb
    begin
        if (is_angle)
        begin
            d_wide = $signed({2'b0, VAL_W'(prev[ANGLE_BITS-1:0])});
            d_wide = $signed({2'b0, VAL_W'(target[ANGLE_BITS-1:0])}) - d_wide;
            if (d_wide < -(VAL_W+2)'(HALF))
                d_wide = d_wide + (VAL_W+2)'(FULL);
            else if (d_wide > (VAL_W+2)'(HALF))
                d_wide = d_wide - (VAL_W+2)'(FULL);
        end
        else
        begin
            d_wide = (VAL_W+2)'($signed(target)) - (VAL_W+2)'($signed(prev));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_wide;
            step_reg <= step;
            dur0_reg <= dur;
            base0_reg <= is_angle ? VAL_W'(prev[ANGLE_BITS-1:0]) : prev;
            angle0_reg <= is_angle;
        end
    end

    assign prod = (PROD_W+2)'(d_reg) * $signed({3'b0, step_reg});
    assign neg = prod[PROD_W+1];
    assign mag = neg ? PROD_W'(-prod) : PROD_W'(prod);

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            sh_w[s] = {rem_reg[s], quo_reg[s][PROD_W-1]};
            trial_w[s] = sh_w[s] - {(PROD_W+1-DUR_W)'(0), dur_reg[s]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            quo_reg[0] <= mag;
            dur_reg[0] <= dur0_reg;
            neg_reg[0] <= neg;
            base_reg[0] <= base0_reg;
            angle_reg[0] <= angle0_reg;
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                quo_reg[s+1] <= {quo_reg[s][PROD_W-2:0], !trial_w[s][PROD_W]};
                neg_reg[s+1] <= neg_reg[s];
                base_reg[s+1] <= base_reg[s];
                angle_reg[s+1] <= angle_reg[s];
            end
            for (int s = 0; s < DIV_STAGES - 1; s++)
            begin
                rem_reg[s+1] <= trial_w[s][PROD_W] ? sh_w[s][PROD_W-1:0]
                                                   : trial_w[s][PROD_W-1:0];
                dur_reg[s+1] <= dur_reg[s];
            end
        end
    end

    logic [VAL_W-1:0] q;
    logic [VAL_W-1:0] sum;
    assign q = neg_reg[DIV_STAGES] ? VAL_W'(-quo_reg[DIV_STAGES])
                                   : VAL_W'(quo_reg[DIV_STAGES]);
    assign sum = base_reg[DIV_STAGES] + q;
    assign value = angle_reg[DIV_STAGES] ? VAL_W'(sum[ANGLE_BITS-1:0]) : sum;

endmodule

@@ rtl/kgi_merge.sv @@
module kgi_merge
    import kgi_pkg::*;
(
    input  side_t             side,
    input  logic [VAL_W-1:0]  lane_a,
    input  logic [VAL_W-1:0]  lane_b,
    input  logic [VAL_W-1:0]  lane_c,
    output out_item_t         result
);

    always_comb
    begin
        result.out_type = side.group_type;
        result.reached_frame = side.reached;
        if (side.reached)
        begin
            result.value_a = side.target_a;
            result.value_b = side.target_b;
            result.value_c = side.target_c;
            result.values_written = 1'b1;
        end
        else if (side.group_type == GROUP_OTHER)
        begin
            result.value_a = '0;
            result.value_b = '0;
            result.value_c = '0;
            result.values_written = 1'b0;
        end
        else
        begin
            result.value_a = lane_a;
            result.value_b = lane_b;
            result.value_c = lane_c;
            result.values_written = 1'b1;
        end
    end

endmodule

@@ rtl/keyframe_group_interpolator.sv @@
// Keyframe group interpolator.
// One item on the input channel (in_valid/in_ready, payload in_item) carries
// one skeleton group; exactly one result item leaves on the output channel
// (out_valid/out_ready, payload out_item) for each, in order.
// Three lanes, one per value, each hold a pipelined multiply and a
// restoring divider with one quotient bit per stage, followed by a merge.
// Each item passes through the lane input registers, the divider stages
// and the output register before it appears on out_valid. Throughput is
// one item per clock while the receiver does not stall the output.
// When the receiver stalls, the whole pipeline freezes and in_ready drops
// only while the output register holds an untaken result; items in flight
// are never lost. Reset clears all valid bits and leaves the output empty.
module keyframe_group_interpolator
    import kgi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int LAT = DIV_STAGES + 2;

    logic en;
    logic [LAT-1:0] vld_reg;
    side_t side_reg [LAT];
    side_t side_in;
    logic is_angle;
    logic [DUR_W-1:0] dur;
    logic [VAL_W-1:0] lane_a, lane_b, lane_c;
    out_item_t merged;
    out_item_t out_reg;
    logic out_vld_reg;

    assign en = !out_vld_reg || out_ready;
    assign in_ready = en;
    assign is_angle = in_item.group_type == GROUP_ROT;
    assign dur = (in_item.frame_duration == '0) ? DUR_W'(1) : in_item.frame_duration;

    always_comb
    begin
        side_in.group_type = in_item.group_type;
        side_in.reached = in_item.elapsed_ticks >= {17'b0, in_item.frame_duration};
        side_in.target_a = in_item.target_a;
        side_in.target_b = in_item.target_b;
        side_in.target_c = in_item.target_c;
    end

    kgi_lane u_lane_a (.clk, .en, .is_angle, .prev(in_item.prev_a),
        .target(in_item.target_a), .step(in_item.elapsed_ticks[DUR_W-1:0]), .dur,
        .value(lane_a));
    kgi_lane u_lane_b (.clk, .en, .is_angle, .prev(in_item.prev_b),
        .target(in_item.target_b), .step(in_item.elapsed_ticks[DUR_W-1:0]), .dur,
        .value(lane_b));
    kgi_lane u_lane_c (.clk, .en, .is_angle, .prev(in_item.prev_c),
        .target(in_item.target_c), .step(in_item.elapsed_ticks[DUR_W-1:0]), .dur,
        .value(lane_c));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
            out_vld_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            out_reg <= merged;
        end
    end

    kgi_merge u_merge (.side(side_reg[LAT-1]), .lane_a, .lane_b, .lane_c,
        .result(merged));

    assign out_valid = out_vld_reg;
    assign out_item = out_reg;

endmodule

@@ test/keyframe_group_checker.sv @@
module keyframe_group_checker
    import kgi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_item,
    output int        fail_count,
    output int        pending,
    output int        checked
);

    out_item_t expected_groups[$];

    function automatic logic [15:0] blend_angle(logic [15:0] src, logic [15:0] dst,
                                                longint step, longint dur);
        longint full;
        longint half;
        longint base;
        longint delta;
        full = longint'(1) << ANGLE_BITS;
        half = longint'(1) << (ANGLE_BITS - 1);
        base = longint'(src) & (full - 1);
        delta = (longint'(dst) & (full - 1)) - base;
        if (delta < -half)
            delta = delta + full;
        else if (delta > half)
            delta = delta - full;
        delta = (delta * step) / dur;
        return 16'((base + delta) & (full - 1));
    endfunction

    function automatic logic [15:0] blend_linear(logic signed [15:0] src,
                                                 logic signed [15:0] dst,
                                                 longint step, longint dur);
        longint delta;
        delta = ((longint'(dst) - longint'(src)) * step) / dur;
        return 16'(longint'(src) + delta);
    endfunction

    function automatic out_item_t interpolate_group(in_item_t g);
        out_item_t r;
        longint dur;
        longint step;
        r = '0;
        r.out_type = g.group_type;
        if (g.elapsed_ticks >= 32'(g.frame_duration))
        begin
            r.value_a = g.target_a;
            r.value_b = g.target_b;
            r.value_c = g.target_c;
            r.values_written = 1'b1;
            r.reached_frame = 1'b1;
            return r;
        end
        dur = (g.frame_duration == 0) ? 1 : longint'(g.frame_duration);
        step = longint'(g.elapsed_ticks);
        if (g.group_type == GROUP_ROT)
        begin
            r.value_a = blend_angle(g.prev_a, g.target_a, step, dur);
            r.value_b = blend_angle(g.prev_b, g.target_b, step, dur);
            r.value_c = blend_angle(g.prev_c, g.target_c, step, dur);
            r.values_written = 1'b1;
        end
        else if (g.group_type == GROUP_MOVE || g.group_type == GROUP_SCALE)
        begin
            r.value_a = blend_linear(g.prev_a, g.target_a, step, dur);
            r.value_b = blend_linear(g.prev_b, g.target_b, step, dur);
            r.value_c = blend_linear(g.prev_c, g.target_c, step, dur);
            r.values_written = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            checked <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_groups.push_back(interpolate_group(in_item));
            if (out_valid && out_ready)
            begin
                checked <= checked + 1;
                if (expected_groups.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("Unexpected result item %p", out_item);
                end
                else
                begin
                    want = expected_groups.pop_front();
                    if (want !== out_item)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("Mismatch: expected %p, got %p", want, out_item);
                    end
                end
            end
        end
    end

    assign pending = expected_groups.size();

endmodule

@@ test/keyframe_group_interpolator_tb.sv @@
module keyframe_group_interpolator_tb
    import kgi_pkg::*;
;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;
    int        fail_count;
    int        pending;
    int        checked;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    bit        hold_off = 1'b0;
    int        cycle_count = 0;
    int        sent = 0;

    always #1 clk = ~clk;

    keyframe_group_interpolator u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
        .out_item(out_item)
    );

    keyframe_group_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
        .out_item(out_item), .fail_count(fail_count), .pending(pending),
        .checked(checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("Timeout with %0d results outstanding.", pending);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(1023));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_group();
        in_item_t g;
        g.group_type = 2'($urandom_range(3));
        g.prev_a = pick_value();
        g.prev_b = pick_value();
        g.prev_c = pick_value();
        g.target_a = pick_value();
        g.target_b = pick_value();
        g.target_c = pick_value();
        case ($urandom_range(9))
            0: g.frame_duration = 15'h7fff;
            1: g.frame_duration = 15'd0;
            2, 3: g.frame_duration = 15'($urandom);
            default: g.frame_duration = 15'($urandom_range(1, 64));
        endcase
        case ($urandom_range(9))
            0: g.elapsed_ticks = $urandom;
            1: g.elapsed_ticks = 32'(g.frame_duration);
            default: g.elapsed_ticks = (g.frame_duration == 0) ? 32'd0
                                       : 32'($urandom_range(g.frame_duration - 1));
        endcase
        return g;
    endfunction

    task automatic send_group(in_item_t g);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= g;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic make_group(logic [1:0] t, logic [15:0] p, logic [15:0] q,
                              logic [31:0] e, logic [14:0] d);
        in_item_t g;
        g.group_type = t;
        g.prev_a = p;
        g.prev_b = ~p;
        g.prev_c = p ^ 16'h0200;
        g.target_a = q;
        g.target_b = ~q;
        g.target_c = q + 16'd512;
        g.elapsed_ticks = e;
        g.frame_duration = d;
        send_group(g);
    endtask

    initial
    begin
        int phase;
        int waited;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        make_group(GROUP_ROT, 16'd0, 16'd512, 32'd1, 15'd2);
        make_group(GROUP_ROT, 16'd512, 16'd0, 32'd1, 15'd2);
        make_group(GROUP_ROT, 16'd10, 16'd1000, 32'd3, 15'd7);
        make_group(GROUP_ROT, 16'd1000, 16'd10, 32'd3, 15'd7);
        make_group(GROUP_ROT, 16'hffff, 16'h8000, 32'd5, 15'd9);
        make_group(GROUP_MOVE, 16'h8000, 16'h7fff, 32'd32766, 15'h7fff);
        make_group(GROUP_MOVE, 16'h7fff, 16'h8000, 32'd1, 15'h7fff);
        make_group(GROUP_SCALE, 16'h8000, 16'h7fff, 32'd1, 15'd3);
        make_group(GROUP_SCALE, 16'h0005, 16'hfffb, 32'd2, 15'd3);
        make_group(GROUP_OTHER, 16'h1234, 16'h4321, 32'd1, 15'd5);
        make_group(GROUP_OTHER, 16'h1234, 16'h4321, 32'd5, 15'd5);
        make_group(GROUP_ROT, 16'h1234, 16'h4321, 32'd0, 15'd0);
        make_group(GROUP_MOVE, 16'h1234, 16'h4321, 32'hffffffff, 15'd0);
        make_group(GROUP_SCALE, 16'h1234, 16'h4321, 32'h80000000, 15'h7fff);
        make_group(GROUP_MOVE, 16'h0000, 16'hffff, 32'd0, 15'd1);
        make_group(GROUP_ROT, 16'h03ff, 16'h0000, 32'd32766, 15'h7fff);
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 63;
                end
                3:
                begin
                    send_idle_pct = 33;
                    recv_stall_pct = 33;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            if (phase == 4)
            begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (200) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            repeat (phase == 4 ? 190 : 280) send_group(random_group());
        end
        in_valid <= 1'b0;
        waited = 0;
        while ((pending != 0 || hold_off) && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        $display("Sent %0d groups of every type through all idle and stall phases,",
                 sent);
        $display("including a long output hold-off; %0d results checked.", checked);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
